[hdl/bpc_pkg.sv]
// Package for the button press classifier: widths, codes, state and event types.
// Used by every module of the block; depends on nothing.
package bpc_pkg;

    localparam int TICK_BITS      = 32;
    localparam int NOW_BITS       = 32;
    localparam int CFG_BITS       = 32;
    localparam int CMP_BITS       = (TICK_BITS > CFG_BITS) ? TICK_BITS : CFG_BITS;
    localparam int CFG_ADDR_BITS  = 2;
    localparam int EVENT_BITS     = 2;
    localparam int IN_FIELD_BITS  = 1 + NOW_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((EVENT_BITS + 7) / 8) * 8;

    typedef logic [TICK_BITS-1:0]     t_tick;
    typedef logic [CFG_BITS-1:0]      t_cfg;
    typedef logic [CFG_ADDR_BITS-1:0] t_cfg_addr;

    localparam t_cfg MIN_PRESS_RESET   = t_cfg'(50);
    localparam t_cfg HOLD_RESET        = t_cfg'(1000);
    localparam t_cfg RELEASE_GAP_RESET = t_cfg'(300);

    localparam t_cfg_addr CFG_MIN_PRESS   = t_cfg_addr'(0);
    localparam t_cfg_addr CFG_HOLD        = t_cfg_addr'(1);
    localparam t_cfg_addr CFG_RELEASE_GAP = t_cfg_addr'(2);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_FIRST  = 3'd1,
        ST_GAP    = 3'd2,
        ST_SECOND = 3'd3,
        ST_WAIT   = 3'd4
    } t_gesture_state;

    typedef enum logic [EVENT_BITS-1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_HOLD   = 2'd3
    } t_event;

    typedef struct packed {
        t_cfg min_press;
        t_cfg hold;
        t_cfg release_gap;
    } t_thresholds;

    // True when the modular elapsed time has reached the limit.
    function automatic logic reached(input t_tick elapsed, input t_cfg limit);
        return CMP_BITS'(elapsed) >= CMP_BITS'(limit);
    endfunction

endpackage

[hdl/bpc_cfg_regs.sv]
// Threshold register file of the button press classifier.
// Depends on bpc_pkg.
module bpc_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  bpc_pkg::t_cfg_addr  i_cfg_addr,
    input  bpc_pkg::t_cfg       i_cfg_wdata,
    output bpc_pkg::t_thresholds o_thr
);
    import bpc_pkg::*;

    t_thresholds r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.min_press   <= MIN_PRESS_RESET;
            r_thr.hold        <= HOLD_RESET;
            r_thr.release_gap <= RELEASE_GAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MIN_PRESS:   r_thr.min_press   <= i_cfg_wdata;
                CFG_HOLD:        r_thr.hold        <= i_cfg_wdata;
                CFG_RELEASE_GAP: r_thr.release_gap <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_thr = r_thr;

endmodule

[hdl/bpc_gesture.sv]
// Gesture state machine and start timestamp; classifies one sample per advance.
// Depends on bpc_pkg.
module bpc_gesture (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_level,
    input  bpc_pkg::t_tick       i_now,
    input  bpc_pkg::t_thresholds i_thr,
    output bpc_pkg::t_event      o_event
);
    import bpc_pkg::*;

    t_gesture_state r_state;
    t_gesture_state n_state;
    t_tick          r_start_tick;
    t_tick          n_start_tick;
    t_tick          elapsed;
    logic           min_ok;
    logic           hold_ok;
    logic           gap_ok;

    assign elapsed = i_now - r_start_tick;
    assign min_ok  = reached(elapsed, i_thr.min_press);
    assign hold_ok = reached(elapsed, i_thr.hold);
    assign gap_ok  = reached(elapsed, i_thr.release_gap);

    always_comb begin
        n_state      = r_state;
        n_start_tick = r_start_tick;
        case (r_state)
            ST_IDLE: begin
                if (!i_level) begin
                    n_state      = ST_FIRST;
                    n_start_tick = i_now;
                end
            end
            ST_FIRST: begin
                if (i_level) begin
                    if (min_ok) begin
                        n_state      = ST_GAP;
                        n_start_tick = i_now;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (hold_ok) begin
                    n_state = ST_WAIT;
                end
            end
            ST_GAP: begin
                if (!i_level) begin
                    n_state      = ST_SECOND;
                    n_start_tick = i_now;
                end else if (gap_ok) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SECOND: begin
                if (i_level || hold_ok) begin
                    n_state = ST_WAIT;
                end
            end
            default: begin
                if (i_level) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_event = EV_NONE;
        case (r_state)
            ST_FIRST: begin
                if (!i_level && hold_ok) begin
                    o_event = EV_HOLD;
                end
            end
            ST_GAP: begin
                if (i_level && gap_ok) begin
                    o_event = EV_SINGLE;
                end
            end
            ST_SECOND: begin
                if (i_level) begin
                    o_event = EV_DOUBLE;
                end else if (hold_ok) begin
                    o_event = EV_HOLD;
                end
            end
            default: o_event = EV_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_start_tick <= '0;
        end else if (i_adv) begin
            r_state      <= n_state;
            r_start_tick <= n_start_tick;
        end
    end

endmodule

[hdl/button_press_classifier.sv]
// Top level of the button press classifier: input register, gesture logic, result register.
// Depends on bpc_pkg, bpc_cfg_regs and bpc_gesture.
//
//  channel   | dir | handshake                        | payload
//  ----------+-----+----------------------------------+-------------------------------
//  sample in | in  | i_s_axis_tvalid/o_s_axis_tready  | level, now_tick
//  event out | out | o_m_axis_tvalid/i_m_axis_tready  | event_res
//  config    | in  | i_cfg_we (no handshake)          | i_cfg_addr, i_cfg_wdata
//
// One beat is accepted every cycle unless the output stalls; its result is registered after it.
// The rate is set by the single state register update of the gesture machine.
// Synchronous active-low reset restores the thresholds and the idle state.
// A stalled result holds in its register while one further beat waits in the input register.
module button_press_classifier (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [0] level, [32:1] now_tick, [39:33] zero
    input  logic [bpc_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [1:0] event_res, [7:2] zero
    output logic [bpc_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata,
    input  logic                               i_cfg_we,
    input  bpc_pkg::t_cfg_addr                 i_cfg_addr,
    input  bpc_pkg::t_cfg                      i_cfg_wdata
);
    import bpc_pkg::*;

    t_thresholds thr;
    logic        r_in_valid;
    logic        r_in_level;
    t_tick       r_in_now;
    logic        r_out_valid;
    t_event      r_out_event;
    t_event      event_res;
    logic        adv;

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;

    bpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_thr       (thr)
    );

    bpc_gesture u_gesture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_level (r_in_level),
        .i_now   (r_in_now),
        .i_thr   (thr),
        .o_event (event_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_level <= i_s_axis_tdata[0];
            r_in_now   <= TICK_BITS'(i_s_axis_tdata[NOW_BITS:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_event <= event_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_BITS'(r_out_event);

endmodule

[hdl/bpc_checker.sv]
// Port-level checks for the button press classifier, bound to the top level.
// Depends on bpc_pkg and button_press_classifier.
module bpc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [bpc_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata
);
    import bpc_pkg::*;

    logic r_seen_final;
    logic out_beat;
    logic final_event;

    assign out_beat    = o_m_axis_tvalid && i_m_axis_tready;
    assign final_event = (o_m_axis_tdata[EVENT_BITS-1:0] == EV_HOLD) ||
                         (o_m_axis_tdata[EVENT_BITS-1:0] == EV_DOUBLE);

    // Remembers whether the last delivered beat was a hold or a double press.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_final <= 1'b0;
        end else if (out_beat) begin
            r_seen_final <= final_event;
        end
    end

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid straight after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_quiet_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_seen_final |-> o_m_axis_tdata[EVENT_BITS-1:0] == EV_NONE)
        else $error("event reported right after a hold or double press");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while the result register is empty");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
